// File: sv/sshm_pkg.sv
// ----------------------------------------------------------------------------
// sshm_pkg
// Shared constants for the stop string holdback matcher: register map,
// field widths, opcodes and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package sshm_pkg;

  localparam int NUM_STOPS_DEF = 4;
  localparam int MAX_LEN_DEF   = 8;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int LEN_FLD_W  = 4;
  localparam int BYTE_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_STOP_LENGTHS = 3'd4;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

`default_nettype wire

// File: sv/stop_string_holdback_matcher_top.sv
// ----------------------------------------------------------------------------
// stop_string_holdback_matcher_top
// Streams text bytes, holds back bytes that may start a stop string, and
// emits text up to the earliest start of a completed stop string.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   in      | input     | in_valid/in_stall  | in_opcode, in_text_byte
//   out     | output    | out_valid/out_stall| out_out_byte, out_out_valid,
//           |           |                    | out_stopped, out_last
//   cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// An input beat is registered, then matched combinationally against all stop
// strings and loaded into a result buffer that drains one beat per cycle while
// out_stall is low. An item that yields several results holds the buffer until
// they drain, so items enter every cycle while each yields at most one result.
// Reset clears the holdback, the stop strings and the lengths.
// out_stall holds the result buffer, and in_stall rises once the registered
// item cannot move into a full result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module stop_string_holdback_matcher_top #(
  parameter int NUM_STOPS = sshm_pkg::NUM_STOPS_DEF,
  parameter int MAX_LEN   = sshm_pkg::MAX_LEN_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [sshm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sshm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_opcode,
  input  wire sshm_pkg::byte_t                in_text_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output sshm_pkg::byte_t                     out_out_byte,
  output logic                                out_out_valid,
  output logic                                out_stopped,
  output logic                                out_last
);

  import sshm_pkg::*;

  localparam int HOLD_DEPTH = (MAX_LEN > 1) ? MAX_LEN - 1 : 1;
  localparam int CNT_W      = $clog2(MAX_LEN + 1);

  logic [CFG_DATA_W-1:0] stop_str_r [NUM_STOPS];
  logic [LEN_FLD_W-1:0]  stop_len_r [NUM_STOPS];

  logic       in_vld_r;
  logic       in_op_r;
  byte_t      in_byte_r;

  byte_t      held_r [HOLD_DEPTH];
  byte_t      held_nxt [HOLD_DEPTH];
  logic [CNT_W-1:0] held_cnt_r;
  logic [CNT_W-1:0] held_cnt_nxt;

  byte_t      bst_byte_r [MAX_LEN];
  logic [CNT_W-1:0] bst_cnt_r;
  logic       bst_bare_r;
  logic       bst_stop_r;

  logic [CNT_W-1:0] slot_len [NUM_STOPS];
  byte_t      rev_b [MAX_LEN];
  byte_t      buf_b [MAX_LEN];
  logic       pm [NUM_STOPS][MAX_LEN+1];
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] longest;
  logic [CNT_W-1:0] best;
  logic [CNT_W-1:0] keep;
  logic [CNT_W-1:0] emit;

  byte_t      res_byte [MAX_LEN];
  logic [CNT_W-1:0] res_cnt;
  logic       res_bare;
  logic       res_stop;

  logic       pop;
  logic       bst_free;
  logic       move;
  logic       accept;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_STOPS; k++) begin
        stop_str_r[k] <= '0;
        stop_len_r[k] <= '0;
      end
    end else if (cfg_we) begin
      for (int k = 0; k < NUM_STOPS; k++) begin
        if (cfg_index == CFG_IDX_W'(k)) begin
          stop_str_r[k] <= cfg_wdata;
        end
        if (cfg_index == REG_STOP_LENGTHS) begin
          stop_len_r[k] <= cfg_wdata[LEN_FLD_W*k +: LEN_FLD_W];
        end
      end
    end
  end

  // handshake
  assign pop      = out_valid && !out_stall;
  assign bst_free = (bst_cnt_r == '0) || ((bst_cnt_r == CNT_W'(1)) && pop);
  assign move     = in_vld_r && bst_free;
  assign in_stall = in_vld_r && !move;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (accept) begin
      in_vld_r <= 1'b1;
    end else if (move) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_op_r   <= in_opcode;
      in_byte_r <= in_text_byte;
    end
  end

  // slot lengths, saturated
  always_comb begin
    longest = '0;
    for (int k = 0; k < NUM_STOPS; k++) begin
      if (stop_len_r[k] > LEN_FLD_W'(MAX_LEN)) begin
        slot_len[k] = CNT_W'(MAX_LEN);
      end else begin
        slot_len[k] = CNT_W'(stop_len_r[k]);
      end
      if (slot_len[k] > longest) begin
        longest = slot_len[k];
      end
    end
  end

  // window: buf_b oldest first, rev_b newest first
  assign total = held_cnt_r + CNT_W'(1);

  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      buf_b[i] = '0;
      rev_b[i] = '0;
    end
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      if (CNT_W'(i) < held_cnt_r) begin
        buf_b[i] = held_r[i];
      end
    end
    for (int i = 0; i < MAX_LEN; i++) begin
      if (held_cnt_r == CNT_W'(i)) begin
        buf_b[i] = in_byte_r;
      end
    end
    rev_b[0] = in_byte_r;
    for (int j = 1; j < MAX_LEN; j++) begin
      for (int h = 0; h < HOLD_DEPTH; h++) begin
        if (int'(held_cnt_r) == h + j) begin
          rev_b[j] = held_r[h];
        end
      end
    end
  end

  // suffix of length n equals first n bytes of slot k
  always_comb begin
    for (int k = 0; k < NUM_STOPS; k++) begin
      pm[k][0] = 1'b1;
      for (int n = 1; n <= MAX_LEN; n++) begin
        pm[k][n] = (n <= int'(total));
        for (int i = 0; i < n; i++) begin
          if (stop_str_r[k][BYTE_W*i +: BYTE_W] != rev_b[n-1-i]) begin
            pm[k][n] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    best = '0;
    keep = '0;
    for (int k = 0; k < NUM_STOPS; k++) begin
      for (int n = 1; n <= MAX_LEN; n++) begin
        if ((int'(slot_len[k]) == n) && pm[k][n] && (slot_len[k] > best)) begin
          best = slot_len[k];
        end
      end
    end
    for (int n = 1; n < MAX_LEN; n++) begin
      for (int k = 0; k < NUM_STOPS; k++) begin
        if ((int'(slot_len[k]) > n) && pm[k][n]) begin
          keep = CNT_W'(n);
        end
      end
    end
  end

  // results and next holdback
  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      res_byte[i] = '0;
    end
    for (int h = 0; h < HOLD_DEPTH; h++) begin
      held_nxt[h] = held_r[h];
    end
    held_cnt_nxt = held_cnt_r;
    res_bare     = 1'b0;
    res_stop     = 1'b0;
    res_cnt      = '0;
    emit         = '0;
    if (in_op_r == OP_FLUSH) begin
      for (int i = 0; i < HOLD_DEPTH; i++) begin
        if (CNT_W'(i) < held_cnt_r) begin
          res_byte[i] = held_r[i];
        end
      end
      res_bare     = (held_cnt_r == '0);
      res_cnt      = res_bare ? CNT_W'(1) : held_cnt_r;
      held_cnt_nxt = '0;
    end else if (longest == '0) begin
      res_byte[0] = in_byte_r;
      res_cnt     = CNT_W'(1);
    end else if (best != '0) begin
      emit = total - best;
      for (int i = 0; i < MAX_LEN; i++) begin
        if (CNT_W'(i) < emit) begin
          res_byte[i] = buf_b[i];
        end
      end
      res_stop     = 1'b1;
      res_bare     = (emit == '0);
      res_cnt      = res_bare ? CNT_W'(1) : emit;
      held_cnt_nxt = '0;
    end else begin
      emit = total - keep;
      for (int i = 0; i < MAX_LEN; i++) begin
        if (CNT_W'(i) < emit) begin
          res_byte[i] = buf_b[i];
        end
      end
      res_cnt = emit;
      for (int h = 0; h < HOLD_DEPTH; h++) begin
        for (int j = 0; j < MAX_LEN; j++) begin
          if (int'(keep) == h + j + 1) begin
            held_nxt[h] = rev_b[j];
          end
        end
      end
      held_cnt_nxt = keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= '0;
    end else if (move) begin
      held_cnt_r <= held_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      for (int h = 0; h < HOLD_DEPTH; h++) begin
        held_r[h] <= held_nxt[h];
      end
    end
  end

  // result buffer, drained from entry zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_cnt_r <= '0;
    end else if (move && (res_cnt != '0)) begin
      bst_cnt_r <= res_cnt;
    end else if (pop) begin
      bst_cnt_r <= bst_cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (move && (res_cnt != '0)) begin
      for (int i = 0; i < MAX_LEN; i++) begin
        bst_byte_r[i] <= res_byte[i];
      end
      bst_bare_r <= res_bare;
      bst_stop_r <= res_stop;
    end else if (pop) begin
      for (int i = 0; i < MAX_LEN - 1; i++) begin
        bst_byte_r[i] <= bst_byte_r[i+1];
      end
      bst_byte_r[MAX_LEN-1] <= '0;
    end
  end

  assign out_valid     = (bst_cnt_r != '0);
  assign out_out_byte  = bst_byte_r[0];
  assign out_out_valid = !bst_bare_r;
  assign out_last      = (bst_cnt_r == CNT_W'(1));
  assign out_stopped   = bst_stop_r && out_last;

`ifndef SYNTHESIS
  a_held_bound : assert property (@(posedge clk) disable iff (!rst_n)
    int'(held_cnt_r) <= HOLD_DEPTH)
    else $error("holdback count exceeds depth");

  a_bst_bound : assert property (@(posedge clk) disable iff (!rst_n)
    int'(bst_cnt_r) <= MAX_LEN)
    else $error("result buffer count exceeds depth");

  a_bare_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_valid |-> out_last)
    else $error("bare marker is not a single beat");

  a_stop_cleared : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stopped |-> held_cnt_r == '0)
    else $error("holdback not cleared after stop");

  a_flush_clears : assert property (@(posedge clk) disable iff (!rst_n)
    move && (in_op_r == OP_FLUSH) |=> held_cnt_r == '0)
    else $error("flush left held bytes");
`endif

endmodule

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives text bytes and flushes into the stop string holdback matcher under
// bursty input and random output stalls, rewrites the stop strings between
// phases, and checks every emitted beat against a scoreboard that tracks the
// stop strings, the held bytes and the expected beat stream.
// ----------------------------------------------------------------------------
module testbench;
  import sshm_pkg::*;

  localparam int NUM_STOPS      = NUM_STOPS_DEF;
  localparam int MAX_LEN        = MAX_LEN_DEF;
  localparam int HOLD_DEPTH     = MAX_LEN - 1;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 22;
  localparam int DRAIN_CYCLES   = 12;
  localparam int HOLDOFF_AT     = 60;
  localparam int HOLDOFF_CYCLES = 150;
  localparam int MAX_REPORTS    = 10;
  localparam int TIMEOUT_CYCLES = 200000;

  localparam logic [CFG_IDX_W-1:0] REG_STOP_STRING_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX    = 3'd7;

  typedef struct packed {
    byte_t data;
    logic  carries_byte;
    logic  stopped;
    logic  last;
  } text_beat_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  class holdback_scoreboard;
    logic [CFG_DATA_W-1:0] stop_word [NUM_STOPS];
    logic [15:0]           len_word;
    byte_t                 held [HOLD_DEPTH];
    int                    held_count;
    text_beat_t            expected_q [$];
    int                    accepted;
    int                    errors;

    function new();
      foreach (stop_word[k]) stop_word[k] = '0;
      len_word   = '0;
      held_count = 0;
      accepted   = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx < REG_STOP_LENGTHS) begin
        stop_word[idx - REG_STOP_STRING_0] = data;
      end else if (idx == REG_STOP_LENGTHS) begin
        len_word = data[15:0];
      end
    endfunction

    function int slot_len(int k);
      int n;
      n = int'(len_word[4*k +: 4]);
      if (n > MAX_LEN) n = MAX_LEN;
      return n;
    endfunction

    function byte_t slot_byte(int k, int i);
      return stop_word[k][8*i +: 8];
    endfunction

    function bit tail_matches(byte_t text [MAX_LEN], int total, int k, int n);
      for (int i = 0; i < n; i++)
        if (slot_byte(k, i) != text[total-n+i]) return 1'b0;
      return 1'b1;
    endfunction

    function void add_beat(byte_t b, logic v, logic s, logic l);
      expected_q.push_back(text_beat_t'{b, v, s, l});
    endfunction

    function void note_input(logic op, byte_t b);
      byte_t text [MAX_LEN];
      int total, longest, best, keep, emit, n;
      accepted++;
      if (op == OP_FLUSH) begin
        for (int i = 0; i < held_count; i++) add_beat(held[i], 1'b1, 1'b0, i == held_count - 1);
        if (held_count == 0) add_beat(8'h00, 1'b0, 1'b0, 1'b1);
        held_count = 0;
        return;
      end
      longest = 0;
      for (int k = 0; k < NUM_STOPS; k++)
        if (slot_len(k) > longest) longest = slot_len(k);
      if (longest == 0) begin
        add_beat(b, 1'b1, 1'b0, 1'b1);
        return;
      end
      for (int i = 0; i < MAX_LEN; i++) text[i] = (i < held_count) ? held[i] : 8'h00;
      text[held_count] = b;
      total = held_count + 1;
      best = 0;
      for (int k = 0; k < NUM_STOPS; k++) begin
        n = slot_len(k);
        if (n > best && n <= total && tail_matches(text, total, k, n)) best = n;
      end
      if (best > 0) begin
        emit = total - best;
        for (int i = 0; i < emit; i++) add_beat(text[i], 1'b1, i == emit - 1, i == emit - 1);
        if (emit == 0) add_beat(8'h00, 1'b0, 1'b1, 1'b1);
        held_count = 0;
        return;
      end
      keep = 0;
      n = (longest - 1 < total) ? longest - 1 : total;
      for (; n > 0 && keep == 0; n--)
        for (int k = 0; k < NUM_STOPS; k++)
          if (keep == 0 && slot_len(k) > n && tail_matches(text, total, k, n)) keep = n;
      emit = total - keep;
      for (int i = 0; i < emit; i++) add_beat(text[i], 1'b1, 1'b0, i == emit - 1);
      for (int i = 0; i < keep; i++) held[i] = text[emit+i];
      held_count = keep;
    endfunction

    function void check_result(text_beat_t got);
      text_beat_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected beat: byte %02h valid %0b stopped %0b last %0b",
                   got.data, got.carries_byte, got.stopped, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"mismatch: expected byte %02h valid %0b stopped %0b last %0b, ",
                    "got %02h %0b %0b %0b"},
                   want.data, want.carries_byte, want.stopped, want.last,
                   got.data, got.carries_byte, got.stopped, got.last);
      end
    endfunction
  endclass

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic                  in_opcode    = OP_PUSH;
  byte_t                 in_text_byte = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  byte_t                 out_out_byte;
  logic                  out_out_valid;
  logic                  out_stopped;
  logic                  out_last;

  holdback_scoreboard sb = new();
  int burst_left = 0;

  stop_string_holdback_matcher_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_text_byte  (in_text_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_out_byte  (out_out_byte),
    .out_out_valid (out_out_valid),
    .out_stopped   (out_stopped),
    .out_last      (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(text_beat_t'{out_out_byte, out_out_valid, out_stopped, out_last});
    end
  end

  task automatic offer(input logic op, input byte_t b);
    @(negedge clk);
    in_valid     = 1'b1;
    in_opcode    = op;
    in_text_byte = b;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, b);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
      repeat ($urandom_range(0, 6)) begin
        @(negedge clk);
        in_valid     = 1'b0;
        in_text_byte = byte_t'($urandom);
      end
    end
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // push the head of a stop string, sometimes spoiling its last byte
  task automatic push_slot_prefix(input int k, input byte_t spoil);
    int n, cnt;
    byte_t b;
    n = sb.slot_len(k);
    if (n == 0) begin
      offer(OP_PUSH, spoil);
    end else begin
      cnt = $urandom_range(1, n);
      for (int i = 0; i < cnt; i++) begin
        b = sb.slot_byte(k, i);
        if (i == cnt - 1 && $urandom_range(0, 5) == 0) b = spoil;
        offer(OP_PUSH, b);
      end
    end
  endtask

  initial begin : receiver
    stall_mode_t mode;
    int run;
    bit held_off;
    held_off = 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      run  = $urandom_range(20, 80);
      repeat (run) begin
        @(negedge clk);
        if (!held_off && sb.accepted >= HOLDOFF_AT) begin
          held_off  = 1'b1;
          out_stall = 1'b1;
          repeat (HOLDOFF_CYCLES) @(negedge clk);
        end
        case (mode)
          STALL_NONE:   out_stall = 1'b0;
          STALL_LIGHT:  out_stall = ($urandom_range(0, 3) == 0);
          STALL_HEAVY:  out_stall = ($urandom_range(0, 3) != 0);
          STALL_TOGGLE: out_stall = !out_stall;
          default:      out_stall = 1'b0;
        endcase
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] word;
    logic [15:0] lengths;
    byte_t alpha [3];
    int pick;
    int target;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // no slot in use: pass through, then a flush with nothing held
    offer(OP_PUSH, 8'h00);
    offer(OP_PUSH, 8'hFF);
    offer(OP_FLUSH, 8'hA5);
    wait_drained();

    // "abcde", "bcd", "cd", plus junk to the unused indexes
    write_cfg(REG_STOP_STRING_0,                64'h0000_0065_6463_6261);
    write_cfg(CFG_IDX_W'(REG_STOP_STRING_0 + 1), 64'h0000_0000_0064_6362);
    write_cfg(CFG_IDX_W'(REG_STOP_STRING_0 + 2), 64'h0000_0000_0000_6463);
    write_cfg(CFG_IDX_W'(REG_STOP_STRING_0 + 3), '1);
    write_cfg(REG_STOP_LENGTHS, 64'h0235);
    for (int i = REG_STOP_LENGTHS + 1; i <= REG_LAST_INDEX; i++) write_cfg(CFG_IDX_W'(i), '1);
    offer(OP_PUSH, 8'h61);
    offer(OP_PUSH, 8'h62);
    offer(OP_PUSH, 8'h63);
    offer(OP_PUSH, 8'h64);
    offer(OP_PUSH, 8'h62);
    offer(OP_PUSH, 8'h63);
    offer(OP_PUSH, 8'h64);
    offer(OP_PUSH, 8'h7A);
    offer(OP_PUSH, 8'h61);
    offer(OP_PUSH, 8'h62);
    offer(OP_FLUSH, 8'h00);
    offer(OP_FLUSH, 8'hFF);
    wait_drained();

    // full-length strings, lengths saturated from the all-ones register
    write_cfg(REG_STOP_STRING_0,                '1);
    write_cfg(CFG_IDX_W'(REG_STOP_STRING_0 + 1), '0);
    write_cfg(CFG_IDX_W'(REG_STOP_STRING_0 + 2), 64'h0123_4567_89AB_CDEF);
    write_cfg(CFG_IDX_W'(REG_STOP_STRING_0 + 3), 64'hFEDC_BA98_7654_3210);
    write_cfg(REG_STOP_LENGTHS, 64'hFFFF);
    repeat (8) offer(OP_PUSH, 8'hFF);
    offer(OP_PUSH, 8'h00);
    offer(OP_PUSH, 8'h00);
    offer(OP_FLUSH, 8'h5A);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      foreach (alpha[i]) alpha[i] = byte_t'($urandom);
      for (int k = 0; k < NUM_STOPS; k++) begin
        for (int i = 0; i < MAX_LEN; i++)
          word[8*i +: 8] = ($urandom_range(0, 9) == 0) ? byte_t'($urandom)
                                                        : alpha[$urandom_range(0, 2)];
        write_cfg(CFG_IDX_W'(REG_STOP_STRING_0 + k), word);
      end
      case (p)
        2: lengths = '0;
        4: lengths = 16'h8888;
        default: begin
          for (int k = 0; k < NUM_STOPS; k++) lengths[4*k +: 4] = 4'($urandom_range(0, 9));
        end
      endcase
      if (p == 1) write_cfg(REG_LAST_INDEX, word);
      write_cfg(REG_STOP_LENGTHS, {48'h0, lengths});
      target = sb.accepted + PHASE_ITEMS;
      while (sb.accepted < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          push_slot_prefix($urandom_range(0, NUM_STOPS - 1), alpha[$urandom_range(0, 2)]);
        end else if (pick < 80) begin
          offer(OP_PUSH, alpha[$urandom_range(0, 2)]);
        end else if (pick < 92) begin
          offer(OP_PUSH, byte_t'($urandom));
        end else begin
          offer(OP_FLUSH, byte_t'($urandom));
        end
      end
      wait_drained();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
